### sv/u8d_pkg.sv
// Package for the UTF-8 to 16-bit code unit stream decoder.
// Holds the item types, the byte classes, the queue sizes and helpers.
// No dependencies; every other file of the block imports it.
package u8d_pkg;

	// Width of the per-string unit counter.
	localparam int COUNT_BITS = 16;

	// Depth of the queue between front and back, and of the result queue.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Width of the capacity comparison: wide enough for counter plus two.
	localparam int CMP_W = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;

	// Reset value of the capacity register.
	localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

	// Byte masks and patterns of the lead-byte classes.
	localparam logic [7:0] ASCII_MASK  = 8'h80;
	localparam logic [7:0] LEAD2_MASK  = 8'hE0;
	localparam logic [7:0] LEAD2_PAT   = 8'hC0;
	localparam logic [7:0] LEAD3_MASK  = 8'hF0;
	localparam logic [7:0] LEAD3_PAT   = 8'hE0;

	// Sequence lengths still to come after a lead byte.
	localparam logic [1:0] REM_NONE = 2'd0;
	localparam logic [1:0] REM_ONE  = 2'd1;
	localparam logic [1:0] REM_TWO  = 2'd2;

	// Class of a byte when it stands in a lead position.
	typedef enum logic [1:0] {
		KIND_ASCII,
		KIND_LEAD2,
		KIND_LEAD3,
		KIND_OTHER
	} byte_kind_t;

	// One input item.
	typedef struct packed {
		logic [7:0] byte_in;
		logic       last_byte;
	} in_item_t;

	// One result item.
	typedef struct packed {
		logic [15:0] code_unit;
		logic        unit_valid;
		logic        end_of_string;
		logic        truncated;
		logic [15:0] unit_count;
	} out_item_t;

	// A classified item as it waits between front and back.
	typedef struct packed {
		byte_kind_t kind;
		logic [7:0] byte_val;
		logic       last;
	} class_item_t;

	// Status of the front queue as the back sees it.
	typedef struct packed {
		logic        avail;
		class_item_t item;
	} front_status_t;

	// Classify a byte by its leading bits.
	function automatic byte_kind_t classify(input logic [7:0] b);
		byte_kind_t k;
		if ((b & ASCII_MASK) == 8'h00) begin
			k = KIND_ASCII;
		end else if ((b & LEAD2_MASK) == LEAD2_PAT) begin
			k = KIND_LEAD2;
		end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
			k = KIND_LEAD3;
		end else begin
			k = KIND_OTHER;
		end
		return k;
	endfunction

	// Bring the unit counter to the 16-bit count field.
	function automatic logic [15:0] count_to_u16(input logic [COUNT_BITS-1:0] c);
		logic [31:0] wide;
		wide = 32'(c);
		return wide[15:0];
	endfunction

endpackage

### sv/u8d_front.sv
// Front part of the decoder: accepts bytes, classifies them as lead bytes
// and holds them in a short queue for the back part. Depends on u8d_pkg.
module u8d_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  u8d_pkg::in_item_t     in_data,
	output u8d_pkg::front_status_t status,
	input  logic                  take
);
	import u8d_pkg::*;

	class_item_t       slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push_ok;
	logic              take_ok;
	class_item_t       new_item;

	// Full is taken from the count alone, so no path runs from the back.
	assign full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign push_ok = push && !full;
	assign take_ok = take && (count_q != '0);

	// Classify the incoming byte on the way into the queue.
	always_comb begin
		new_item.kind     = classify(in_data.byte_in);
		new_item.byte_val = in_data.byte_in;
		new_item.last     = in_data.last_byte;
	end

	// Oldest queued item as seen by the back.
	assign status.avail = (count_q != '0);
	assign status.item  = slot_q[rd_ptr_q];

	// Queue storage; payload needs no reset.
	always_ff @(posedge clk) begin
		if (push_ok) begin
			slot_q[wr_ptr_q] <= new_item;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (take_ok) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push_ok, take_ok})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// The fill count never passes the depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("front queue count exceeds depth");

	// A push into a queue that was full is refused and leaves the count alone.
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !take) |=> (count_q == $past(count_q)))
		else $error("front queue count moved while full and not drained");

	// The back never takes from an empty queue.
	a_take_avail: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> (count_q != '0))
		else $error("back took an item from an empty front queue");

endmodule

### sv/u8d_back.sv
// Back part of the decoder: keeps the per-string state, builds code units
// from classified bytes and queues result items. Depends on u8d_pkg.
module u8d_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  u8d_pkg::front_status_t status,
	output logic                   take,
	output logic                   empty,
	input  logic                   pop,
	output u8d_pkg::out_item_t     out_data,
	input  logic                   cfg_wr_en,
	input  logic [15:0]            cfg_wr_data
);
	import u8d_pkg::*;

	// Capacity register and per-string decode state.
	logic [15:0]           capacity_q;
	logic [15:0]           part_q;
	logic [1:0]            rem_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic                  stopped_q;

	// Result queue.
	out_item_t             res_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]     wr_ptr_q;
	logic [QPTR_W-1:0]     rd_ptr_q;
	logic [QCNT_W-1:0]     count_q;

	logic                  pop_ok;
	logic                  space;
	logic                  emit;
	out_item_t             result;
	logic [15:0]           n_part;
	logic [1:0]            n_rem;
	logic                  n_stop;
	logic                  valid;
	logic [15:0]           unit;
	logic [COUNT_BITS-1:0] n_cnt;
	logic                  at_limit;
	logic [7:0]            b;

	assign empty  = (count_q == '0);
	assign pop_ok = pop && !empty;
	assign space  = (count_q != QCNT_W'(QUEUE_DEPTH)) || pop_ok;
	assign take   = status.avail && space;
	assign out_data = res_q[rd_ptr_q];
	assign b      = status.item.byte_val;

	// Capacity check done before every byte in a lead position.
	assign at_limit = (CMP_W'(cnt_q) + CMP_W'(2)) >= CMP_W'(capacity_q);

	// Decode one classified byte against the current state.
	always_comb begin
		n_part = part_q;
		n_rem  = rem_q;
		n_stop = stopped_q;
		valid  = 1'b0;
		unit   = '0;
		if (!stopped_q) begin
			if (rem_q != REM_NONE) begin
				if (rem_q == REM_TWO) begin
					n_part = part_q | {4'b0, b[5:0], 6'b0};
				end else begin
					n_part = part_q | {10'b0, b[5:0]};
				end
				n_rem = rem_q - 1'b1;
				if (n_rem == REM_NONE) begin
					valid = 1'b1;
					unit  = n_part;
				end
			end else if (at_limit) begin
				n_stop = 1'b1;
			end else begin
				unique case (status.item.kind)
					KIND_ASCII: begin
						valid = 1'b1;
						unit  = {8'b0, b};
					end
					KIND_LEAD2: begin
						n_part = {5'b0, b[4:0], 6'b0};
						n_rem  = REM_ONE;
					end
					KIND_LEAD3: begin
						n_part = {b[3:0], 12'b0};
						n_rem  = REM_TWO;
					end
					default: begin
						n_part = part_q;
					end
				endcase
			end
		end
		// A string cut short still emits its partial unit.
		if (status.item.last && !n_stop && (n_rem != REM_NONE)) begin
			valid = 1'b1;
			unit  = n_part;
			n_rem = REM_NONE;
		end
		// The counter saturates at all ones.
		if (valid && (cnt_q != '1)) begin
			n_cnt = cnt_q + 1'b1;
		end else begin
			n_cnt = cnt_q;
		end
		emit                 = status.item.last || valid;
		result.code_unit     = valid ? unit : '0;
		result.unit_valid    = valid;
		result.end_of_string = status.item.last;
		result.truncated     = status.item.last && n_stop;
		result.unit_count    = status.item.last ? count_to_u16(n_cnt) : '0;
	end

	// Capacity register; the user must write it only while idle, the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (cfg_wr_en) begin
			capacity_q <= cfg_wr_data;
		end
	end

	// Per-string state; the last byte clears it for the next string.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q    <= '0;
			rem_q     <= REM_NONE;
			cnt_q     <= '0;
			stopped_q <= 1'b0;
		end else if (take) begin
			if (status.item.last) begin
				part_q    <= '0;
				rem_q     <= REM_NONE;
				cnt_q     <= '0;
				stopped_q <= 1'b0;
			end else begin
				part_q    <= n_part;
				rem_q     <= n_rem;
				cnt_q     <= n_cnt;
				stopped_q <= n_stop;
			end
		end
	end

	// Result queue storage.
	always_ff @(posedge clk) begin
		if (take && emit) begin
			res_q[wr_ptr_q] <= result;
		end
	end

	// Result queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (take && emit) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({take && emit, pop_ok})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// The result queue never overflows.
	a_res_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("result queue count exceeds depth");

	// An item that does not close a string is queued only with a unit.
	a_mid_unit: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !out_data.end_of_string) |-> out_data.unit_valid)
		else $error("mid-string result without a unit");

	// Once stopped, no unit is emitted until the string ends.
	a_stop_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(take && stopped_q) |-> !valid)
		else $error("unit emitted after the capacity stop");

	// The state is clear after a string closes.
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(take && status.item.last) |=> (cnt_q == '0 && rem_q == REM_NONE && !stopped_q))
		else $error("string state not cleared after last byte");

endmodule

### sv/utf8_to_ucs2_stream_decoder_unit.sv
// Top level of the UTF-8 to 16-bit code unit stream decoder.
// Joins the front (classify and queue) and the back (decode and results).
// Depends on u8d_pkg, u8d_front and u8d_back.
//
// Usage: bytes of a string enter as items on the input queue interface; an
// item is taken at a clock edge with push high and full low. last_byte marks
// the final byte of a string. Results leave on the output queue interface:
// the oldest result sits on out_data while empty is low and is taken at an
// edge with pop high. A byte mid-string yields a result only when it
// completes a code unit; the last byte always yields one result that closes
// the string and reports the unit count and the truncation flag.
// An accepted byte passes through the front queue, then the result queue,
// before empty goes low. Throughput is one byte per cycle while the result
// queue has space, set by the combinational decode step of the back part.
// If the receiver stalls, the result queue fills, the back stops taking from
// the front queue, and full rises once that queue is full; nothing is lost.
// Reset clears both queues and the string state and sets buffer_capacity to
// 65535. buffer_capacity is written through cfg_wr_en and cfg_wr_data; the
// user must write it only while idle; the block itself does not enforce this.
module utf8_to_ucs2_stream_decoder_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  u8d_pkg::in_item_t  in_data,
	output logic               empty,
	input  logic               pop,
	output u8d_pkg::out_item_t out_data,
	input  logic               cfg_wr_en,
	input  logic [15:0]        cfg_wr_data
);
	import u8d_pkg::*;

	front_status_t status;
	logic          take;

	// Front part: classification and hand-off queue.
	u8d_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.in_data (in_data),
		.status  (status),
		.take    (take)
	);

	// Back part: decode state, capacity check and result queue.
	u8d_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.status      (status),
		.take        (take),
		.empty       (empty),
		.pop         (pop),
		.out_data    (out_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

endmodule

### tb/tb_utf8_to_ucs2_stream_decoder_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the UTF-8 to 16-bit code unit stream decoder.
// Drives byte items through the queue ports and predicts every result item.
// Depends on u8d_pkg and utf8_to_ucs2_stream_decoder_unit.
module tb_utf8_to_ucs2_stream_decoder_unit;
	import u8d_pkg::*;

	localparam int STALL_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_BYTES   = 160;

	typedef logic [7:0] byte_q_t[$];

	typedef enum int {
		POP_ALWAYS,
		POP_COIN,
		POP_BURSTY,
		POP_SPARSE
	} pop_mode_t;

	// Predicts the decoder and checks its result items in order.
	class utf8_unit_scoreboard;
		logic [15:0]           capacity;
		logic [15:0]           partial;
		logic [1:0]            remaining;
		logic [COUNT_BITS-1:0] emitted;
		bit                    halted;
		out_item_t             expected_units[$];
		int                    errors;
		int                    units_checked;
		int                    strings_closed;
		int                    strings_cut;

		function new();
			capacity = CAPACITY_RESET;
			errors = 0;
			units_checked = 0;
			strings_closed = 0;
			strings_cut = 0;
			clear_string();
		endfunction

		function void clear_string();
			partial = '0;
			remaining = REM_NONE;
			emitted = '0;
			halted = 1'b0;
		endfunction

		function void set_capacity(logic [15:0] value);
			capacity = value;
		endfunction

		function int pending();
			return expected_units.size();
		endfunction

		// Advance the string state by one accepted byte item.
		function void note_byte(in_item_t item);
			logic [7:0]  b;
			logic [15:0] unit;
			bit          last;
			bit          valid;
			out_item_t   res;
			b = item.byte_in;
			last = item.last_byte;
			valid = 1'b0;
			unit = '0;
			if (!halted) begin
				if (remaining != REM_NONE) begin
					// Continuation bits are taken unchecked.
					partial = partial | ({10'b0, b[5:0]} << ((remaining == REM_TWO) ? 6 : 0));
					remaining = remaining - 2'd1;
					if (remaining == REM_NONE) begin
						valid = 1'b1;
						unit = partial;
					end
				end else if (longint'(emitted) + 2 >= longint'(capacity)) begin
					halted = 1'b1;
				end else if ((b & ASCII_MASK) == 8'h00) begin
					valid = 1'b1;
					unit = {8'h00, b};
				end else if ((b & LEAD2_MASK) == LEAD2_PAT) begin
					partial = {5'b0, b[4:0], 6'b0};
					remaining = REM_ONE;
				end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
					partial = {b[3:0], 12'b0};
					remaining = REM_TWO;
				end
			end
			// A string that ends mid-sequence still yields its partial unit.
			if (last && !halted && remaining != REM_NONE) begin
				valid = 1'b1;
				unit = partial;
				remaining = REM_NONE;
			end
			if (valid && emitted != '1) begin
				emitted = emitted + 1'b1;
			end
			if (!last && !valid) begin
				return;
			end
			res.code_unit = valid ? unit : 16'h0000;
			res.unit_valid = valid;
			res.end_of_string = last;
			res.truncated = last && halted;
			res.unit_count = last ? 16'(emitted) : 16'h0000;
			expected_units.push_back(res);
			if (last) begin
				strings_closed++;
				if (halted) begin
					strings_cut++;
				end
				clear_string();
			end
		endfunction

		function void compare_field(string name, logic [15:0] expv, logic [15:0] gotv);
			if (gotv !== expv) begin
				$error("%s: expected %0h, got %0h", name, expv, gotv);
				errors++;
			end
		endfunction

		// Compare one accepted result item with the oldest prediction.
		function void check_unit(out_item_t got);
			out_item_t want;
			if (expected_units.size() == 0) begin
				$error("result item with nothing expected: %h", got);
				errors++;
				return;
			end
			want = expected_units.pop_front();
			units_checked++;
			compare_field("code_unit", want.code_unit, got.code_unit);
			compare_field("unit_valid", 16'(want.unit_valid), 16'(got.unit_valid));
			compare_field("end_of_string", 16'(want.end_of_string), 16'(got.end_of_string));
			compare_field("truncated", 16'(want.truncated), 16'(got.truncated));
			compare_field("unit_count", want.unit_count, got.unit_count);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        push;
	logic        full;
	in_item_t    in_data;
	logic        empty;
	logic        pop;
	out_item_t   out_data;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;

	utf8_unit_scoreboard sb;
	int        idle_cycles;
	int        bytes_sent;
	int        burst_left;
	pop_mode_t pop_mode;
	int        mode_left;
	int        stall_left;

	utf8_to_ucs2_stream_decoder_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.in_data     (in_data),
		.empty       (empty),
		.pop         (pop),
		.out_data    (out_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// Clock with a 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Sample both handshakes and the register write; watch for a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wr_en) begin
				sb.set_capacity(cfg_wr_data);
			end
			if (pop && !empty) begin
				sb.check_unit(out_data);
			end
			if (push && !full) begin
				sb.note_byte(in_data);
			end
			if ((push && !full) || (pop && !empty)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= STALL_LIMIT) begin
					$display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
					$display("status: fail");
					$finish;
				end
			end
		end
	end

	// The receiver switches between stall patterns chosen at random.
	always @(negedge clk) begin
		if (mode_left == 0) begin
			pop_mode = pop_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(16, 96);
		end
		mode_left--;
		case (pop_mode)
			POP_ALWAYS: begin
				pop <= 1'b1;
			end
			POP_COIN: begin
				pop <= 1'($urandom_range(0, 1));
			end
			POP_BURSTY: begin
				if (stall_left > 0) begin
					pop <= 1'b0;
					stall_left--;
				end else begin
					pop <= 1'b1;
					if ($urandom_range(0, 7) == 0) begin
						stall_left = $urandom_range(5, 20);
					end
				end
			end
			default: begin
				pop <= ($urandom_range(0, 3) == 0);
			end
		endcase
	end

	// Present one byte item and hold it until it is taken.
	task automatic send_byte(input logic [7:0] value, input logic last);
		in_item_t item;
		item.byte_in = value;
		item.last_byte = last;
		@(negedge clk);
		push <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (full);
		bytes_sent++;
	endtask

	task automatic pause_sender(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			push <= 1'b0;
		end
	endtask

	// Send a byte as part of a burst; a new burst starts after a random gap.
	task automatic send_paced(input logic [7:0] value, input logic last);
		if (burst_left == 0) begin
			pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
			                                         : $urandom_range(1, 16);
		end
		burst_left--;
		send_byte(value, last);
	endtask

	// Send a whole string; the final byte carries the last flag.
	task automatic send_string(input byte_q_t bytes);
		foreach (bytes[i]) begin
			send_paced(bytes[i], i == bytes.size() - 1);
		end
	endtask

	// Hold the sender until every predicted result has come out.
	task automatic drain_results();
		pause_sender(1);
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [15:0] value);
		drain_results();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Build a string of mostly well-formed characters with random content.
	task automatic send_random_string(input int chars);
		byte_q_t bytes;
		int      pick;
		int      cont;
		for (int i = 0; i < chars; i++) begin
			cont = 0;
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				bytes.push_back(8'($urandom_range(0, 127)));
			end else if (pick < 60) begin
				bytes.push_back(8'hC0 | 8'($urandom_range(0, 31)));
				cont = 1;
			end else if (pick < 88) begin
				bytes.push_back(8'hE0 | 8'($urandom_range(0, 15)));
				cont = 2;
			end else begin
				// Any byte with the top bit set, such as a stray continuation or a long lead.
				bytes.push_back(8'($urandom_range(128, 255)));
			end
			// Now and then the string ends inside a sequence.
			if (i == chars - 1 && cont > 0 && $urandom_range(0, 4) == 0) begin
				cont = $urandom_range(0, cont - 1);
			end
			repeat (cont) begin
				if ($urandom_range(0, 7) == 0) begin
					bytes.push_back(8'($urandom_range(0, 255)));
				end else begin
					bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
				end
			end
		end
		send_string(bytes);
	endtask

	initial begin
		byte_q_t     bytes;
		logic [15:0] cap;
		int          target;
		sb = new();
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		in_data = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		idle_cycles = 0;
		bytes_sent = 0;
		burst_left = 0;
		pop_mode = POP_ALWAYS;
		mode_left = 0;
		stall_left = 0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// Reset capacity: field extremes, every byte class, stray bytes.
		bytes = '{8'h00, 8'h7F, 8'hC2, 8'hA9, 8'hDF, 8'hBF, 8'hE2, 8'h82, 8'hAC,
		          8'hEF, 8'hBF, 8'hBF, 8'h80, 8'hF0, 8'hFF, 8'h41};
		send_string(bytes);
		// A string cut short inside a three-byte and a two-byte sequence.
		bytes = '{8'hE2, 8'h82};
		send_string(bytes);
		bytes = '{8'hC3};
		send_string(bytes);
		// A string that is a single skipped byte.
		bytes = '{8'hFF};
		send_string(bytes);

		// Capacity two: the check fails at the first lead position.
		write_capacity(16'd2);
		bytes = '{8'h41, 8'h42};
		send_string(bytes);
		// One unit fits, then decoding stops.
		write_capacity(16'd3);
		bytes = '{8'h41, 8'h42, 8'h43};
		send_string(bytes);
		// Capacity below two flags any string.
		write_capacity(16'd0);
		bytes = '{8'h41};
		send_string(bytes);

		// Random strings over several capacity settings.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: cap = 16'($urandom_range(4, 10));
				1: cap = 16'($urandom_range(11, 40));
				2: cap = 16'hFFFF;
				3: cap = 16'($urandom_range(2, 65535));
				4: cap = 16'd3;
				default: cap = 16'($urandom_range(5, 24));
			endcase
			write_capacity(cap);
			target = bytes_sent + PHASE_BYTES;
			while (bytes_sent < target) begin
				send_random_string(($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
				                                               : $urandom_range(1, 12));
			end
		end

		drain_results();
		$display("covered %0d bytes in %0d strings, %0d of them cut at capacity",
		         bytes_sent, sb.strings_closed, sb.strings_cut);
		$display("checked %0d result items, %0d mismatches", sb.units_checked, sb.errors);
		if (sb.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
